// ===== hw/rtl/ffha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
package ffha_pkg;
    localparam int unsigned HeapGranules = 256;
    localparam int unsigned GW = $clog2(HeapGranules);      // granule index width
    localparam int unsigned SW = GW + 1;                    // block size width
    localparam int unsigned HW = SW + 1;                    // header word width

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;        // load request, clear walk state
        logic rd;           // read header at walk pointer
        logic rd_at;        // read header at next block address
        logic [1:0] rd_sel; // 0 walk, 1 next, 2 prev
        logic step;         // latch read data as current and advance, or as next block (rd_sel next)
        logic wr;           // write
        logic [2:0] wr_op;  // which write
    } t_ctrl;

    // destination of a header read
    localparam logic [1:0] RSEL_WALK = 2'd0;
    localparam logic [1:0] RSEL_NEXT = 2'd1;
    localparam logic [1:0] RSEL_PREV = 2'd2;

    localparam logic [2:0] WR_ALLOC_HEAD = 3'd0;
    localparam logic [2:0] WR_ALLOC_REM  = 3'd1;
    localparam logic [2:0] WR_CLR_CUR    = 3'd2;
    localparam logic [2:0] WR_CLR_NXT    = 3'd3;
    localparam logic [2:0] WR_MERGE      = 3'd4;
    localparam logic [2:0] WR_INIT       = 3'd5;

    // datapath to controller
    typedef struct packed {
        logic at_end;      // walk pointer at or past heap end
        logic fits;        // current block free and large enough
        logic match;       // current block payload offset equals request
        logic cur_alloc;
        logic has_rem;
        logic nxt_in;      // next block inside heap
        logic nxt_free;
        logic prv_free;    // previous block exists and is free
        logic clr_done;
    } t_stat;
endpackage

// ===== hw/rtl/ffha_if.sv =====
// valid/ready stream channel
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [11:0] request_size;
    logic [11:0] free_offset;
    modport source (output valid, command, request_size, free_offset, input ready);
    modport sink   (input valid, command, request_size, free_offset, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] payload_offset;
    modport source (output valid, status, payload_offset, input ready);
    modport sink   (input valid, status, payload_offset, output ready);
endinterface

// ===== hw/rtl/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator over 256 granules of 16 bytes. After reset a clearing
// pass initializes the header memory; no request is taken then. Each request
// walks the block list from granule 0 and passes each block through the states
// S_READ, S_LATCH and S_CHECK (one header memory read per block) before any
// headers are written; a free also merges with free neighbours. One request is
// in flight at a time and the next is taken once the result has been transferred.
module first_fit_heap_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    req,
    ffha_rsp_if.source  rsp
);
    import ffha_pkg::*;

    t_ctrl       w_ctrl;
    t_stat       w_stat;
    logic [11:0] w_off;

    ffha_ctrl u_ctrl (
        .i_clk, .i_rst_n, .req, .rsp,
        .i_stat(w_stat), .i_payload_offset(w_off), .o_ctrl(w_ctrl)
    );

    ffha_datapath u_dp (
        .i_clk, .i_rst_n, .i_ctrl(w_ctrl),
        .i_request_size(req.request_size), .i_free_offset(req.free_offset),
        .o_stat(w_stat), .o_payload_offset(w_off)
    );
endmodule

// ===== hw/rtl/ffha_datapath.sv =====
// header memory, walk pointer and merge arithmetic
module ffha_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffha_pkg::t_ctrl  i_ctrl,
    input  logic [11:0]      i_request_size,
    input  logic [11:0]      i_free_offset,
    output ffha_pkg::t_stat  o_stat,
    output logic [11:0]      o_payload_offset
);
    import ffha_pkg::*;

    logic [HW-1:0] mem [HeapGranules];
    logic [HW-1:0] r_rdata;
    logic [SW-1:0] r_g;        // walk pointer, may reach heap size
    logic [SW-1:0] r_cur;      // current block start
    logic [SW-1:0] r_cur_sz;
    logic          r_cur_al;
    logic [SW-1:0] r_prv;
    logic [SW-1:0] r_prv_sz;
    logic          r_prv_al;
    logic          r_has_prv;
    logic [SW-1:0] r_need;
    logic [11:0]   r_foff;
    logic [SW-1:0] r_nxt_sz;
    logic          r_nxt_al;
    logic [GW-1:0] r_clr;
    logic          r_clr_done;
    logic [1:0]    r_rsel;

    logic [SW-1:0] w_sz;
    logic [SW-1:0] w_nxt;
    logic [GW-1:0] w_addr;
    logic [HW-1:0] w_wdata;
    logic [SW-1:0] w_msize;
    logic [SW+3:0] w_hoff;

    // size of the just-read header, zero guarded to one
    assign w_sz  = (r_rdata[HW-1:1] == '0) ? SW'(1) : r_rdata[HW-1:1];
    assign w_nxt = r_cur + r_cur_sz;
    assign w_hoff = {r_cur, 4'b1000};

    // merged free size
    always_comb begin
        w_msize = r_cur_sz;
        if (r_has_prv && !r_prv_al) w_msize = w_msize + r_prv_sz;
        if (o_stat.nxt_in && !r_nxt_al) w_msize = w_msize + r_nxt_sz;
    end

    // write address and data
    always_comb begin
        w_addr  = r_cur[GW-1:0];
        w_wdata = '0;
        case (i_ctrl.wr_op)
            WR_ALLOC_HEAD: w_wdata = {(o_stat.has_rem ? r_need : r_cur_sz), 1'b1};
            WR_ALLOC_REM: begin
                w_addr  = GW'(r_cur + r_need);
                w_wdata = {SW'(r_cur_sz - r_need), 1'b0};
            end
            WR_CLR_CUR:   w_wdata = '0;
            WR_CLR_NXT: begin
                w_addr  = w_nxt[GW-1:0];
                w_wdata = '0;
            end
            WR_MERGE: begin
                w_addr  = (r_has_prv && !r_prv_al) ? r_prv[GW-1:0] : r_cur[GW-1:0];
                w_wdata = {w_msize, 1'b0};
            end
            WR_INIT: begin
                w_addr  = r_clr;
                w_wdata = (r_clr == '0) ? {SW'(HeapGranules), 1'b0} : '0;
            end
            default: w_wdata = '0;
        endcase
    end

    // header memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) mem[w_addr] <= w_wdata;
        if (i_ctrl.rd) begin
            if (i_ctrl.rd_at) r_rdata <= mem[w_nxt[GW-1:0]];
            else              r_rdata <= mem[r_g[GW-1:0]];
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g <= '0; r_has_prv <= 1'b0; r_clr <= '0; r_clr_done <= 1'b0;
            r_cur <= '0; r_cur_sz <= SW'(1); r_cur_al <= 1'b0; r_rsel <= RSEL_WALK;
        end else begin
            if (i_ctrl.wr && i_ctrl.wr_op == WR_INIT) begin
                r_clr <= r_clr + GW'(1);
                if (r_clr == GW'(HeapGranules - 1)) r_clr_done <= 1'b1;
            end
            if (i_ctrl.rd) r_rsel <= i_ctrl.rd_sel;
            if (i_ctrl.start) begin
                r_g <= '0; r_has_prv <= 1'b0;
                r_need <= SW'((13'(i_request_size) + 13'd23) >> 4);
                r_foff <= i_free_offset;
            end else if (i_ctrl.step) begin
                if (r_rsel == RSEL_NEXT) begin
                    r_nxt_sz <= w_sz; r_nxt_al <= r_rdata[0];
                end else begin
                    r_prv <= r_cur; r_prv_sz <= r_cur_sz; r_prv_al <= r_cur_al;
                    r_has_prv <= (r_g != '0);
                    r_cur <= r_g; r_cur_sz <= w_sz; r_cur_al <= r_rdata[0];
                    r_g <= r_g + w_sz;
                end
            end
        end
    end

    always_comb begin
        o_stat.at_end    = (r_g >= SW'(HeapGranules));
        o_stat.fits      = !r_cur_al && (r_cur_sz >= r_need);
        o_stat.match     = (w_hoff == (SW+4)'(r_foff));
        o_stat.cur_alloc = r_cur_al;
        o_stat.has_rem   = (r_cur_sz > r_need);
        o_stat.nxt_in    = (w_nxt < SW'(HeapGranules));
        o_stat.nxt_free  = !r_nxt_al;
        o_stat.prv_free  = r_has_prv && !r_prv_al;
        o_stat.clr_done  = r_clr_done;
    end

    assign o_payload_offset = w_hoff[11:0];
endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// request sequencer of the allocator
module ffha_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ffha_req_if.sink        req,
    ffha_rsp_if.source      rsp,
    input  ffha_pkg::t_stat i_stat,
    input  logic [11:0]     i_payload_offset,
    output ffha_pkg::t_ctrl o_ctrl
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_LATCH, S_CHECK, S_REM, S_NRD, S_NLATCH,
        S_FCLR, S_NCLR, S_MERGE, S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_cmd;
    logic    r_ovalid, n_ovalid;
    t_status r_status, n_status;
    logic [11:0] r_off, n_off;

    assign req.ready          = (r_state == S_IDLE) && !r_ovalid;
    assign rsp.valid          = r_ovalid;
    assign rsp.status         = r_status;
    assign rsp.payload_offset = r_off;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !rsp.ready;
        n_status = r_status;
        n_off    = r_off;
        o_ctrl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.wr = 1'b1; o_ctrl.wr_op = WR_INIT;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: if (req.valid && !r_ovalid) begin
                o_ctrl.start = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_stat.at_end) begin
                    n_status = (r_cmd == CMD_ALLOC) ? ST_NOFIT : ST_INVALID;
                    n_off = '0; n_state = S_DONE;
                end else begin
                    o_ctrl.rd = 1'b1; n_state = S_LATCH;
                end
            end
            S_LATCH: begin o_ctrl.step = 1'b1; n_state = S_CHECK; end
            S_CHECK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (i_stat.fits) begin
                        o_ctrl.wr = 1'b1; o_ctrl.wr_op = WR_ALLOC_HEAD;
                        n_status = ST_OK; n_off = i_payload_offset;
                        n_state = i_stat.has_rem ? S_REM : S_DONE;
                    end else n_state = S_READ;
                end else if (i_stat.match) begin
                    n_off = '0;
                    if (!i_stat.cur_alloc) begin
                        n_status = ST_INVALID; n_state = S_DONE;
                    end else begin
                        n_status = ST_OK; n_state = S_NRD;
                    end
                end else n_state = S_READ;
            end
            S_REM: begin
                o_ctrl.wr = 1'b1; o_ctrl.wr_op = WR_ALLOC_REM; n_state = S_DONE;
            end
            S_NRD: begin
                o_ctrl.rd = 1'b1; o_ctrl.rd_at = 1'b1; o_ctrl.rd_sel = RSEL_NEXT;
                n_state = S_NLATCH;
            end
            S_NLATCH: begin o_ctrl.step = 1'b1; n_state = S_FCLR; end
            S_FCLR: begin
                o_ctrl.wr = 1'b1; o_ctrl.wr_op = WR_CLR_CUR; n_state = S_NCLR;
            end
            S_NCLR: begin
                if (i_stat.nxt_in && i_stat.nxt_free) begin
                    o_ctrl.wr = 1'b1; o_ctrl.wr_op = WR_CLR_NXT;
                end
                n_state = S_MERGE;
            end
            S_MERGE: begin
                o_ctrl.wr = 1'b1; o_ctrl.wr_op = WR_MERGE; n_state = S_DONE;
            end
            S_DONE: begin n_ovalid = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_ovalid <= 1'b0; r_status <= ST_OK; r_off <= '0;
            r_cmd <= CMD_ALLOC;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_status <= n_status;
            r_off <= n_off;
            if (o_ctrl.start) r_cmd <= req.command;
        end
    end
endmodule

// ===== hw/rtl/ffha_checker.sv =====
// port-level checks of the allocator
module ffha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [11:0] rsp_off
);
    import ffha_pkg::*;

    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_status <= ST_INVALID) else $error("bad status");
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_off == 12'd0) else $error("offset on fail");
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> rsp_off[2:0] == 3'd0) else $error("misaligned offset");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_off)) else $error("result dropped");
endmodule

bind first_fit_heap_allocator_top ffha_checker u_chk (
    .i_clk, .i_rst_n,
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_off(rsp.payload_offset)
);
